[sv/gzhp_pkg.sv]
`default_nettype none

package gzhp_pkg;

    // Width of the byte position and header end counters.
    localparam int COUNT_WIDTH = 32;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Fixed header bytes.
    localparam logic [7:0] MAGIC_ID1      = 8'h1f;
    localparam logic [7:0] MAGIC_ID2      = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'h08;

    // Bit positions in the FLG byte.
    localparam int FLG_HCRC    = 1;
    localparam int FLG_EXTRA   = 2;
    localparam int FLG_NAME    = 3;
    localparam int FLG_COMMENT = 4;

    // Member layout.
    localparam int FIXED_LEN   = 10;
    localparam int TRAILER_LEN = 8;
    localparam int MIN_MEMBER  = 18;

    typedef enum logic [2:0] {
        ST_OK,
        ST_SHORT,
        ST_MAGIC,
        ST_EXTRA,
        ST_NAME,
        ST_COMMENT,
        ST_NO_TRAILER
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] deflate_offset;
        logic [31:0] deflate_length;
        logic [31:0] uncompressed_size;
    } result_item_t;

endpackage

`default_nettype wire

[sv/gzip_header_parser.sv]
// A final byte is captured in the input register, and its result then in the result register.
// Throughput: one byte per cycle; the input register holds a byte only while a
// final byte waits for the result register to empty.
// Reset: rst_n clears the registers' valid flags and the parser to the start of a member.
// After each final byte the parser returns to that state for the next member.
`default_nettype none

module gzip_header_parser (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      byte_valid,
    output logic                     byte_stall,
    input  gzhp_pkg::byte_item_t     byte_item,
    output logic                     result_valid,
    input  wire                      result_stall,
    output gzhp_pkg::result_item_t   result_item
);
    import gzhp_pkg::*;

    logic         held_valid;
    byte_item_t   held_item;
    logic         take;
    logic         out_ready;
    logic         out_load;
    result_item_t parse_result;

    // A held byte moves on unless it closes a member and the result slot is full and stalled.
    assign take     = held_valid && (!held_item.last_byte || out_ready);
    assign out_load = take && held_item.last_byte;

    gzhp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    gzhp_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .item   (held_item),
        .result (parse_result)
    );

    gzhp_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (out_load),
        .load_item    (parse_result),
        .ready        (out_ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

[sv/gzhp_in_stage.sv]
`default_nettype none

module gzhp_in_stage (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      byte_valid,
    output logic                     byte_stall,
    input  gzhp_pkg::byte_item_t     byte_item,
    input  wire                      take,
    output logic                     held_valid,
    output gzhp_pkg::byte_item_t     held_item
);
    import gzhp_pkg::*;

    logic       valid_reg;
    byte_item_t item_reg;
    logic       load;

    // The held byte blocks a new request only while it cannot move on.
    assign byte_stall = valid_reg && !take;
    assign load       = byte_valid && !byte_stall;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    // Valid flag of the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload of the input register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= byte_item;
        end
    end

endmodule

`default_nettype wire

[sv/gzhp_parse.sv]
`default_nettype none

module gzhp_parse (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      step,
    input  gzhp_pkg::byte_item_t     item,
    output gzhp_pkg::result_item_t   result
);
    import gzhp_pkg::*;

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_XLO,
        PH_XHI,
        PH_EXTRA,
        PH_NAME,
        PH_COMMENT,
        PH_DATA
    } phase_t;

    localparam logic [COUNT_WIDTH-1:0] ROOM_MAX = CNT_MAX - COUNT_WIDTH'(TRAILER_LEN);

    // Saturating add of a small constant to a counter.
    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [1:0]             k
    );
        logic [COUNT_WIDTH:0] sum;
        sum = {1'b0, a} + (COUNT_WIDTH+1)'(k);
        if (sum[COUNT_WIDTH])
        begin
            sat_add = CNT_MAX;
        end
        else
        begin
            sat_add = sum[COUNT_WIDTH-1:0];
        end
    endfunction

    // First optional header part at or after 'from' that FLG asks for.
    function automatic phase_t next_part(input phase_t from, input logic [7:0] flg);
        phase_t res;
        priority if (from <= PH_XLO && flg[FLG_EXTRA])
        begin
            res = PH_XLO;
        end
        else if (from <= PH_NAME && flg[FLG_NAME])
        begin
            res = PH_NAME;
        end
        else if (from <= PH_COMMENT && flg[FLG_COMMENT])
        begin
            res = PH_COMMENT;
        end
        else
        begin
            res = PH_DATA;
        end
        return res;
    endfunction

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0] room_reg, room_next;
    logic [COUNT_WIDTH-1:0] hend_reg, hend_next;
    logic [7:0]             flags_reg, flags_next;
    logic [15:0]            extra_reg, extra_next;
    logic                   magic_bad_reg, magic_bad_next;
    logic [31:0]            tail_reg, tail_next;

    logic [COUNT_WIDTH-1:0] hend_adv;
    logic [15:0]            extra_hi;
    logic [15:0]            extra_dec;
    logic [7:0]             b;
    status_t                status;

    assign b         = item.data_byte;
    assign extra_hi  = {b, extra_reg[7:0]};
    assign extra_dec = extra_reg - 16'd1;
    assign hend_adv  = flags_reg[FLG_HCRC] ? sat_add(pos_reg, 2'd3) : sat_add(pos_reg, 2'd1);

    // Header walk for one byte.
    always_comb
    begin
        phase_next     = phase_reg;
        flags_next     = flags_reg;
        extra_next     = extra_reg;
        magic_bad_next = magic_bad_reg;
        hend_next      = hend_reg;
        pos_next       = sat_add(pos_reg, 2'd1);
        tail_next      = {b, tail_reg[31:8]};

        // The room count is the trailer start if this byte were the last one.
        if (pos_reg >= COUNT_WIDTH'(TRAILER_LEN - 1) && room_reg != ROOM_MAX)
        begin
            room_next = room_reg + COUNT_WIDTH'(1);
        end
        else
        begin
            room_next = room_reg;
        end

        unique case (phase_reg)
            PH_FIXED:
            begin
                if ((pos_reg == COUNT_WIDTH'(0) && b != MAGIC_ID1) ||
                    (pos_reg == COUNT_WIDTH'(1) && b != MAGIC_ID2) ||
                    (pos_reg == COUNT_WIDTH'(2) && b != METHOD_DEFLATE))
                begin
                    magic_bad_next = 1'b1;
                end
                if (pos_reg == COUNT_WIDTH'(3))
                begin
                    flags_next = b;
                end
                if (pos_reg == COUNT_WIDTH'(FIXED_LEN - 1))
                begin
                    phase_next = next_part(PH_XLO, flags_reg);
                end
            end
            PH_XLO:
            begin
                extra_next = {8'h00, b};
                phase_next = PH_XHI;
            end
            PH_XHI:
            begin
                extra_next = extra_hi;
                if (extra_hi == 16'd0)
                begin
                    phase_next = next_part(PH_NAME, flags_reg);
                end
                else
                begin
                    phase_next = PH_EXTRA;
                end
            end
            PH_EXTRA:
            begin
                extra_next = extra_dec;
                if (extra_dec == 16'd0)
                begin
                    phase_next = next_part(PH_NAME, flags_reg);
                end
            end
            PH_NAME:
            begin
                if (b == 8'h00)
                begin
                    phase_next = next_part(PH_COMMENT, flags_reg);
                end
            end
            PH_COMMENT:
            begin
                if (b == 8'h00)
                begin
                    phase_next = next_part(PH_DATA, flags_reg);
                end
            end
            PH_DATA:
            begin
            end
            default:
            begin
            end
        endcase

        // The header end is fixed when the data phase is entered.
        if (phase_reg != PH_DATA && phase_next == PH_DATA)
        begin
            hend_next = hend_adv;
        end
    end

    // Status of the member when this byte closes it.
    always_comb
    begin
        priority if (pos_reg < COUNT_WIDTH'(MIN_MEMBER - 1))
        begin
            status = ST_SHORT;
        end
        else if (magic_bad_reg)
        begin
            status = ST_MAGIC;
        end
        else if (phase_next == PH_FIXED || phase_next == PH_XLO || phase_next == PH_XHI)
        begin
            status = ST_EXTRA;
        end
        else if (phase_next == PH_EXTRA)
        begin
            if (flags_reg[FLG_NAME])
            begin
                status = ST_NAME;
            end
            else if (flags_reg[FLG_COMMENT])
            begin
                status = ST_COMMENT;
            end
            else
            begin
                status = ST_NO_TRAILER;
            end
        end
        else if (phase_next == PH_NAME)
        begin
            status = ST_NAME;
        end
        else if (phase_next == PH_COMMENT)
        begin
            status = ST_COMMENT;
        end
        else if (phase_reg != PH_DATA || hend_reg > room_reg)
        begin
            // A header that ends on the final byte leaves no trailer room.
            status = ST_NO_TRAILER;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // Result fields, zero unless the member is good.
    always_comb
    begin
        result.status            = status;
        result.deflate_offset    = 32'd0;
        result.deflate_length    = 32'd0;
        result.uncompressed_size = 32'd0;
        if (status == ST_OK)
        begin
            result.deflate_offset    = 32'(hend_reg);
            result.deflate_length    = 32'(room_reg - hend_reg);
            result.uncompressed_size = tail_next;
        end
    end

    // Parser state; a final byte returns it to the start of a member.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIXED;
            pos_reg       <= '0;
            room_reg      <= '0;
            hend_reg      <= '0;
            flags_reg     <= 8'h00;
            extra_reg     <= 16'd0;
            magic_bad_reg <= 1'b0;
            tail_reg      <= 32'd0;
        end
        else if (step)
        begin
            if (item.last_byte)
            begin
                phase_reg     <= PH_FIXED;
                pos_reg       <= '0;
                room_reg      <= '0;
                hend_reg      <= '0;
                flags_reg     <= 8'h00;
                extra_reg     <= 16'd0;
                magic_bad_reg <= 1'b0;
                tail_reg      <= 32'd0;
            end
            else
            begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                room_reg      <= room_next;
                hend_reg      <= hend_next;
                flags_reg     <= flags_next;
                extra_reg     <= extra_next;
                magic_bad_reg <= magic_bad_next;
                tail_reg      <= tail_next;
            end
        end
    end

    // A final byte starts the next member from position zero.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.last_byte |=> pos_reg == '0 && phase_reg == PH_FIXED)
        else $error("parser did not restart after the final byte");

    // The trailer room stays behind the byte position.
    a_room_bound: assert property (@(posedge clk) disable iff (!rst_n)
        room_reg <= pos_reg)
        else $error("trailer room ahead of byte position");

    // No room exists before the trailer can fit.
    a_room_start: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < COUNT_WIDTH'(TRAILER_LEN) |-> room_reg == '0)
        else $error("trailer room counted too early");

    // The extra field phase always has bytes left to skip.
    a_extra_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EXTRA |-> extra_reg != 16'd0)
        else $error("extra field phase with nothing to skip");

endmodule

`default_nettype wire

[sv/gzhp_out_stage.sv]
`default_nettype none

module gzhp_out_stage (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      load,
    input  gzhp_pkg::result_item_t   load_item,
    output logic                     ready,
    output logic                     result_valid,
    input  wire                      result_stall,
    output gzhp_pkg::result_item_t   result_item
);
    import gzhp_pkg::*;

    logic         valid_reg;
    result_item_t item_reg;

    // Room for a new result when empty or when the held one leaves now.
    assign ready        = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result_item  = item_reg;

    // Valid flag of the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload of the result register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !(valid_reg && result_stall))
        else $error("result register overwritten while stalled");

    // A loaded result is presented in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> valid_reg)
        else $error("loaded result not presented");

    // An empty register stays empty without a load.
    a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg && !load |=> !valid_reg)
        else $error("result appeared without a load");

endmodule

`default_nettype wire
